/* src/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Request codes and payload structs shared by the sorted timer queue
// modules, and the deadline compare used by the sequencer.
// ----------------------------------------------------------------------------
package stq_pkg;

   // Default size of the timer pool.
   localparam int STQ_NUM_TIMERS = 16;

   // Request codes.
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_START  = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // One request on the input channel.
   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  timer_id;
      logic [15:0] gap_ticks;
   } stq_req_type;

   // One expiry report on the result channel.
   typedef struct packed {
      logic [3:0] fired_id;
      logic       last_fired;
   } stq_rsp_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      logic        valid;
      stq_rsp_type data;
   } stq_emit_type;

   // True when deadline a lies strictly after deadline b, by signed difference.
   function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return (diff != 32'd0) && !diff[31];
   endfunction

endpackage

/* src/sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue
// A pool of one-shot timers kept in deadline order; ticks report expiries.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready as one stq_req_type: tick, start,
// delete or clear. Only a tick produces results; each expired timer comes
// out on rsp_valid/rsp_ready as one stq_rsp_type, in deadline order, with
// last_fired set on the final one of that tick.
// req_ready is high only while the sequencer is idle, so one request is
// worked on at a time. The sequencer walks the slot list through a single
// read port, one entry per step. A delete, or a restart before its insert,
// finds the slot and moves the entries behind it down one place; a start
// searches for the insert point and moves the entries behind it up; a tick
// unlinks each expired timer from the head of the list. The list moves
// grow with the square of NUM_TIMERS, above all when one tick expires
// every timer. Results pass through an output register, so a new request
// is accepted while the last result still waits; a stalled receiver holds
// the tick in progress until each result is taken. Reset clears the tick
// counter and disarms every timer.
// ----------------------------------------------------------------------------
module sorted_timer_queue import stq_pkg::*; #(
   parameter int NUM_TIMERS = STQ_NUM_TIMERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  stq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output stq_rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(NUM_TIMERS);

   logic              out_free;
   stq_emit_type      emit;
   logic [SLOT_W-1:0] ord_raddr;
   logic [SLOT_W-1:0] ord_rdata;
   logic              ord_we;
   logic [SLOT_W-1:0] ord_waddr;
   logic [SLOT_W-1:0] ord_wdata;
   logic [SLOT_W-1:0] dl_raddr;
   logic [31:0]       dl_rdata;
   logic              dl_we;
   logic [SLOT_W-1:0] dl_waddr;
   logic [31:0]       dl_wdata;
   logic              rsp_valid_ff, rsp_valid_in;
   stq_rsp_type       rsp_data_ff, rsp_data_in;

   stq_seq #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .emit      (emit),
      .ord_raddr (ord_raddr),
      .ord_rdata (ord_rdata),
      .ord_we    (ord_we),
      .ord_waddr (ord_waddr),
      .ord_wdata (ord_wdata),
      .dl_raddr  (dl_raddr),
      .dl_rdata  (dl_rdata),
      .dl_we     (dl_we),
      .dl_waddr  (dl_waddr),
      .dl_wdata  (dl_wdata)
   );

   stq_store #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_store (
      .clock     (clock),
      .ord_raddr (ord_raddr),
      .ord_rdata (ord_rdata),
      .ord_we    (ord_we),
      .ord_waddr (ord_waddr),
      .ord_wdata (ord_wdata),
      .dl_raddr  (dl_raddr),
      .dl_rdata  (dl_rdata),
      .dl_we     (dl_we),
      .dl_waddr  (dl_waddr),
      .dl_wdata  (dl_wdata)
   );

   // The output register can take a result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/stq_store.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue storage
// The ordered slot list and the per-slot deadlines, each one memory with a
// single write port and a registered read port.
// ----------------------------------------------------------------------------
module stq_store import stq_pkg::*; #(
   parameter int  NUM_TIMERS = STQ_NUM_TIMERS,
   localparam int SLOT_W     = $clog2(NUM_TIMERS)
) (
   input  logic              clock,
   input  logic [SLOT_W-1:0] ord_raddr,
   output logic [SLOT_W-1:0] ord_rdata,
   input  logic              ord_we,
   input  logic [SLOT_W-1:0] ord_waddr,
   input  logic [SLOT_W-1:0] ord_wdata,
   input  logic [SLOT_W-1:0] dl_raddr,
   output logic [31:0]       dl_rdata,
   input  logic              dl_we,
   input  logic [SLOT_W-1:0] dl_waddr,
   input  logic [31:0]       dl_wdata
);

   logic [SLOT_W-1:0] order_mem [NUM_TIMERS];
   logic [31:0]       deadline_mem [NUM_TIMERS];
   logic [SLOT_W-1:0] ord_rdata_ff;
   logic [31:0]       dl_rdata_ff;

   // Slot list in deadline order.
   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      ord_rdata_ff <= order_mem[ord_raddr];
   end

   // Deadline of each slot.
   always_ff @(posedge clock) begin
      if (dl_we) begin
         deadline_mem[dl_waddr] <= dl_wdata;
      end
      dl_rdata_ff <= deadline_mem[dl_raddr];
   end

   assign ord_rdata = ord_rdata_ff;
   assign dl_rdata  = dl_rdata_ff;

endmodule

/* src/stq_seq.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue sequencer
// Walks the ordered slot list one entry at a time to find, unlink, insert
// and expire timers, using the storage read ports and the package deadline compare.
// ----------------------------------------------------------------------------
module stq_seq import stq_pkg::*; #(
   parameter int  NUM_TIMERS = STQ_NUM_TIMERS,
   localparam int SLOT_W     = $clog2(NUM_TIMERS),
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stq_req_type       req_data,
   input  logic              out_free,
   output stq_emit_type      emit,
   output logic [SLOT_W-1:0] ord_raddr,
   input  logic [SLOT_W-1:0] ord_rdata,
   output logic              ord_we,
   output logic [SLOT_W-1:0] ord_waddr,
   output logic [SLOT_W-1:0] ord_wdata,
   output logic [SLOT_W-1:0] dl_raddr,
   input  logic [31:0]       dl_rdata,
   output logic              dl_we,
   output logic [SLOT_W-1:0] dl_waddr,
   output logic [31:0]       dl_wdata
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_U_FRD  = 4'd1;
   localparam logic [3:0] S_U_FCK  = 4'd2;
   localparam logic [3:0] S_U_SRD  = 4'd3;
   localparam logic [3:0] S_U_SWR  = 4'd4;
   localparam logic [3:0] S_L_RD1  = 4'd5;
   localparam logic [3:0] S_L_RD2  = 4'd6;
   localparam logic [3:0] S_L_CMP  = 4'd7;
   localparam logic [3:0] S_L_SH   = 4'd8;
   localparam logic [3:0] S_L_SWR  = 4'd9;
   localparam logic [3:0] S_T_RD1  = 4'd10;
   localparam logic [3:0] S_T_RD2  = 4'd11;
   localparam logic [3:0] S_T_CMP  = 4'd12;
   localparam logic [3:0] S_T_EMIT = 4'd13;
   localparam logic [3:0] S_T_FIN  = 4'd14;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [31:0]           new_dl_ff, new_dl_in;
   logic [31:0]           now_ff, now_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      shift_ff, shift_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_id_ff, pend_id_in;

   logic              req_fire;
   logic [SLOT_W-1:0] req_slot;
   logic              id_ok;
   logic [CNT_W-1:0]  scan_p1;
   logic [CNT_W-1:0]  shift_m1;
   logic [31:0]       start_dl;

   assign req_fire = req_valid && req_ready;
   assign req_slot = SLOT_W'(req_data.timer_id);
   assign id_ok    = ({28'd0, req_data.timer_id} < 32'(NUM_TIMERS));
   assign scan_p1  = scan_ff + CNT_W'(1);
   assign shift_m1 = shift_ff - CNT_W'(1);
   assign start_dl = now_ff + {16'd0, req_data.gap_ticks};

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      new_dl_in     = new_dl_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      shift_in      = shift_ff;
      armed_in      = armed_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      req_ready     = (state_ff == S_IDLE);
      ord_raddr     = scan_ff[SLOT_W-1:0];
      ord_we        = 1'b0;
      ord_waddr     = scan_ff[SLOT_W-1:0];
      ord_wdata     = slot_ff;
      dl_raddr      = ord_rdata;
      dl_we         = 1'b0;
      dl_waddr      = req_slot;
      dl_wdata      = start_dl;
      emit          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_data.req_type;
               scan_in = '0;
               case (req_data.req_type)
                  REQ_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = S_T_RD1;
                  end
                  REQ_START: begin
                     if ((req_data.gap_ticks != 16'd0) && id_ok) begin
                        dl_we     = 1'b1;
                        slot_in   = req_slot;
                        new_dl_in = start_dl;
                        state_in  = armed_ff[req_slot] ? S_U_FRD : S_L_RD1;
                     end
                  end
                  REQ_DELETE: begin
                     if (id_ok && armed_ff[req_slot]) begin
                        slot_in  = req_slot;
                        state_in = S_U_FRD;
                     end
                  end
                  default: begin
                     count_in = '0;
                     armed_in = '0;
                  end
               endcase
            end
         end

         // Find the list position of the slot being removed.
         S_U_FRD: begin
            ord_raddr = scan_ff[SLOT_W-1:0];
            state_in  = S_U_FCK;
         end
         S_U_FCK: begin
            if (ord_rdata == slot_ff) begin
               state_in = S_U_SRD;
            end else begin
               scan_in  = scan_p1;
               state_in = S_U_FRD;
            end
         end

         // Close the gap by moving later entries down one place.
         S_U_SRD: begin
            if (scan_p1 < count_ff) begin
               ord_raddr = scan_p1[SLOT_W-1:0];
               state_in  = S_U_SWR;
            end else begin
               count_in          = count_ff - CNT_W'(1);
               armed_in[slot_ff] = 1'b0;
               scan_in           = '0;
               case (op_ff)
                  REQ_TICK:  state_in = S_T_RD1;
                  REQ_START: state_in = S_L_RD1;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_U_SWR: begin
            ord_we    = 1'b1;
            ord_waddr = scan_ff[SLOT_W-1:0];
            ord_wdata = ord_rdata;
            scan_in   = scan_p1;
            state_in  = S_U_SRD;
         end

         // Search for the first entry whose deadline is later than the new one.
         S_L_RD1: begin
            if (scan_ff == count_ff) begin
               shift_in = count_ff;
               state_in = S_L_SH;
            end else begin
               ord_raddr = scan_ff[SLOT_W-1:0];
               state_in  = S_L_RD2;
            end
         end
         S_L_RD2: begin
            dl_raddr = ord_rdata;
            state_in = S_L_CMP;
         end
         S_L_CMP: begin
            if (later_than(dl_rdata, new_dl_ff)) begin
               shift_in = count_ff;
               state_in = S_L_SH;
            end else begin
               scan_in  = scan_p1;
               state_in = S_L_RD1;
            end
         end

         // Open a hole at the insert position, then drop the slot into it.
         S_L_SH: begin
            if (shift_ff > scan_ff) begin
               ord_raddr = shift_m1[SLOT_W-1:0];
               state_in  = S_L_SWR;
            end else begin
               ord_we            = 1'b1;
               ord_waddr         = scan_ff[SLOT_W-1:0];
               ord_wdata         = slot_ff;
               count_in          = count_ff + CNT_W'(1);
               armed_in[slot_ff] = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_L_SWR: begin
            ord_we    = 1'b1;
            ord_waddr = shift_ff[SLOT_W-1:0];
            ord_wdata = ord_rdata;
            shift_in  = shift_m1;
            state_in  = S_L_SH;
         end

         // Look at the head of the list after a tick.
         S_T_RD1: begin
            if (count_ff == '0) begin
               state_in = S_T_FIN;
            end else begin
               ord_raddr = '0;
               state_in  = S_T_RD2;
            end
         end
         S_T_RD2: begin
            dl_raddr = ord_rdata;
            slot_in  = ord_rdata;
            state_in = S_T_CMP;
         end
         S_T_CMP: begin
            if (later_than(dl_rdata, now_ff)) begin
               state_in = S_T_FIN;
            end else if (pend_valid_ff) begin
               state_in = S_T_EMIT;
            end else begin
               pend_valid_in = 1'b1;
               pend_id_in    = slot_ff;
               scan_in       = '0;
               state_in      = S_U_SRD;
            end
         end

         // An earlier expiry is held back until we know whether it is the last.
         S_T_EMIT: begin
            if (out_free) begin
               emit.valid           = 1'b1;
               emit.data.fired_id   = 4'(pend_id_ff);
               emit.data.last_fired = 1'b0;
               pend_id_in           = slot_ff;
               scan_in              = '0;
               state_in             = S_U_SRD;
            end
         end
         S_T_FIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit.valid           = 1'b1;
               emit.data.fired_id   = 4'(pend_id_ff);
               emit.data.last_fired = 1'b1;
               pend_valid_in        = 1'b0;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         armed_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         armed_ff      <= armed_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      new_dl_ff  <= new_dl_in;
      scan_ff    <= scan_in;
      shift_ff   <= shift_in;
      pend_id_ff <= pend_id_in;
   end

   // The armed flags and the list length agree whenever the list is settled.
   property p_count_matches_flags;
      @(posedge clock) disable iff (reset)
         (state_ff == S_IDLE) |-> ($countones(armed_ff) == int'(count_ff));
   endproperty
   a_count_matches_flags: assert property (p_count_matches_flags)
      else $error("armed flags and list length disagree");

   // A result is only handed over when the output register can take it.
   property p_emit_needs_room;
      @(posedge clock) disable iff (reset)
         emit.valid |-> out_free;
   endproperty
   a_emit_needs_room: assert property (p_emit_needs_room)
      else $error("result issued while output register is full");

   // No expiry is left behind once a tick has finished.
   property p_idle_no_pending;
      @(posedge clock) disable iff (reset)
         (state_ff == S_IDLE) |-> !pend_valid_ff;
   endproperty
   a_idle_no_pending: assert property (p_idle_no_pending)
      else $error("expiry still pending in idle");

   // A tick advances the counter by exactly one.
   property p_tick_advances;
      @(posedge clock) disable iff (reset)
         (req_fire && (req_data.req_type == REQ_TICK)) |=>
            (now_ff == ($past(now_ff) + 32'd1));
   endproperty
   a_tick_advances: assert property (p_tick_advances)
      else $error("tick did not advance the counter");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Sends tick, start, delete and clear requests to sorted_timer_queue. A
// timer list model in the bench predicts each expiry report, and every
// report is checked field by field in arrival order. The tests cover directed
// corner cases, a full timer pool, random traffic under changing idle
// patterns, and a long receiver stall that backs requests up.
// ----------------------------------------------------------------------------
module tb;
   import stq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   stq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   stq_rsp_type rsp_data;

   // Idle percentages for each side, and the long receiver stall request.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_serial = 0;
   int hold_length = 0;

   int mismatch_count = 0;

   // Timer list model state.
   logic [31:0] now_ticks = '0;
   logic [31:0] slot_deadline [STQ_NUM_TIMERS];
   logic [STQ_NUM_TIMERS-1:0] slot_armed = '0;
   int          armed_order [$];
   stq_rsp_type pending_fires [$];

   sorted_timer_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Give up after a generous fixed time.
   initial begin
      #20_000_000;
      $display("** sorted_timer_queue: FAILED **");
      $finish;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // True when deadline a is strictly later than deadline b, so a wrapped
   // counter still orders correctly.
   function automatic bit due_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return (diff != 32'd0) && !diff[31];
   endfunction

   // Take a slot out of the deadline list and disarm it.
   function automatic void disarm_slot(input int slot);
      for (int i = 0; i < armed_order.size(); i++) begin
         if (armed_order[i] == slot) begin
            armed_order.delete(i);
            break;
         end
      end
      slot_armed[slot] = 1'b0;
   endfunction

   // Apply one accepted request to the timer list and queue the expiries it
   // should report.
   function automatic void model_timer_request(input stq_req_type r);
      int          slot;
      int          pos;
      stq_rsp_type fire;
      slot = int'(r.timer_id);
      case (r.req_type)
         REQ_TICK: begin
            now_ticks = now_ticks + 32'd1;
            while (armed_order.size() > 0 &&
                   !due_after(slot_deadline[armed_order[0]], now_ticks)) begin
               fire.fired_id = 4'(armed_order.pop_front());
               slot_armed[fire.fired_id] = 1'b0;
               fire.last_fired = (armed_order.size() == 0) ||
                                 due_after(slot_deadline[armed_order[0]], now_ticks);
               pending_fires.push_back(fire);
            end
         end
         REQ_START: begin
            if (r.gap_ticks != 16'd0 && slot < STQ_NUM_TIMERS) begin
               if (slot_armed[slot])
                  disarm_slot(slot);
               slot_deadline[slot] = now_ticks + 32'(r.gap_ticks);
               // A new timer goes behind every timer that is not due later.
               pos = 0;
               while (pos < armed_order.size() &&
                      !due_after(slot_deadline[armed_order[pos]], slot_deadline[slot]))
                  pos++;
               armed_order.insert(pos, slot);
               slot_armed[slot] = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (slot < STQ_NUM_TIMERS && slot_armed[slot])
               disarm_slot(slot);
         end
         REQ_CLEAR: begin
            armed_order.delete();
            slot_armed = '0;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic stq_req_type make_request(input logic [1:0] kind, input int slot,
                                                input int gap);
      stq_req_type r;
      r.req_type  = kind;
      r.timer_id  = 4'(slot);
      r.gap_ticks = 16'(gap);
      return r;
   endfunction

   // Mostly well-formed traffic: short timers that expire soon, plus some
   // zero gaps, far deadlines, deletes and the odd clear.
   function automatic stq_req_type random_request();
      stq_req_type r;
      int          roll;
      r.req_type  = 2'($urandom_range(3));
      r.timer_id  = 4'($urandom_range(15));
      r.gap_ticks = 16'($urandom_range(65535));
      roll = $urandom_range(99);
      if (roll < 40) begin
         r.req_type = REQ_TICK;
      end else if (roll < 80) begin
         r.req_type = REQ_START;
         roll = $urandom_range(99);
         if (roll < 4)
            r.gap_ticks = '0;
         else if (roll < 86)
            r.gap_ticks = 16'($urandom_range(12, 1));
      end else if (roll < 97) begin
         r.req_type = REQ_DELETE;
      end else begin
         r.req_type = REQ_CLEAR;
      end
      return r;
   endfunction

   // Offer one request, wait for the handshake, then update the model.
   // Valid stays high into the next request unless the sender idles.
   task automatic send_request(input stq_req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      model_timer_request(r);
   endtask

   // Stop offering requests until every predicted expiry has been reported.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_fires.size() != 0);
   endtask

   // Receiver: random stalls, or a long hold when a test asks for one.
   initial begin : receiver
      int seen;
      int hold_left;
      seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_serial != seen) begin
            seen = hold_serial;
            hold_left = hold_length;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each accepted expiry report with the oldest prediction.
   always @(posedge clock) begin : fire_checker
      stq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fires.size() == 0) begin
            report_mismatch($sformatf("unexpected expiry of slot %0d", rsp_data.fired_id));
         end else begin
            want = pending_fires.pop_front();
            if (rsp_data.fired_id !== want.fired_id)
               report_mismatch($sformatf("fired_id %0d, wanted %0d",
                                         rsp_data.fired_id, want.fired_id));
            if (rsp_data.last_fired !== want.last_fired)
               report_mismatch($sformatf("last_fired %0b on slot %0d, wanted %0b",
                                         rsp_data.last_fired, want.fired_id,
                                         want.last_fired));
         end
      end
   end

   // Quiet ticks, zero gap, unarmed delete, equal deadlines, restart, clear.
   task automatic test_directed_cases();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_request(make_request(REQ_TICK, $urandom_range(15), $urandom_range(65535)));
      send_request(make_request(REQ_START, 0, 0));
      send_request(make_request(REQ_DELETE, 5, 16'hFFFF));
      send_request(make_request(REQ_START, 15, 16'hFFFF));
      send_request(make_request(REQ_START, 3, 2));
      send_request(make_request(REQ_START, 7, 2));
      send_request(make_request(REQ_START, 9, 1));
      // Restarting slot 3 moves it behind slot 9 with the same deadline.
      send_request(make_request(REQ_START, 3, 1));
      send_request(make_request(REQ_TICK, 0, 0));
      send_request(make_request(REQ_TICK, 15, 16'hFFFF));
      send_request(make_request(REQ_DELETE, 15, 0));
      send_request(make_request(REQ_START, 12, 5));
      send_request(make_request(REQ_START, 10, 3));
      send_request(make_request(REQ_CLEAR, $urandom_range(15), $urandom_range(65535)));
      send_request(make_request(REQ_TICK, 10, 3));
      wait_for_results();
   endtask

   // Arm every slot, restart one in a full list, and expire all in one tick.
   task automatic test_full_pool();
      int offset;
      offset = $urandom_range(15);
      for (int k = 0; k < STQ_NUM_TIMERS; k++)
         send_request(make_request(REQ_START, (k * 7 + offset) % STQ_NUM_TIMERS, 2));
      send_request(make_request(REQ_START, offset, 2));
      send_request(make_request(REQ_TICK, 0, 0));
      send_request(make_request(REQ_TICK, 0, 0));
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int sender_idle,
                                      input int receiver_idle);
      req_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      for (int n = 0; n < count; n++)
         send_request(random_request());
      wait_for_results();
   endtask

   // Hold the result channel for a long stretch during a full expiry so
   // the block stalls its input while requests keep coming.
   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int k = 0; k < STQ_NUM_TIMERS; k++)
         send_request(make_request(REQ_START, STQ_NUM_TIMERS - 1 - k, 1));
      hold_length = 400;
      hold_serial++;
      send_request(make_request(REQ_TICK, 0, 0));
      for (int n = 0; n < 8; n++)
         send_request(random_request());
      wait_for_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_pool();
      test_random_traffic(90, 11, 57);
      test_random_traffic(90, 57, 11);
      test_random_traffic(90, 0, 0);
      test_output_backpressure();
      // Let any stray report show up before the verdict.
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** sorted_timer_queue: PASSED **");
      end else begin
         $display("** sorted_timer_queue: FAILED **");
      end
      $finish;
   end

endmodule
